### hw/rtl/assert_macros.svh
// Assertion macros used by the controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check on clock, muted while reset is high.
`define ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Concurrent check on clock, active during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`endif

### hw/rtl/bbcc_pkg.sv
// Types, constants and codes shared by the buffer cache controller modules.
`default_nettype none
package bbcc_pkg;
   localparam int NUM_BUFFERS = 16;
   localparam int IDX_W = $clog2(NUM_BUFFERS);
   localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
   localparam int MAX_DIRTY_PCT = 127;
   localparam int PROD_W = $clog2(MAX_DIRTY_PCT * NUM_BUFFERS + 1);
   // x / 100 == (x * 5243) >> 19 for every x below 43000
   localparam int RECIP_100 = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W = 13;
   localparam int THRESH_W = PROD_W + RECIP_W - RECIP_SHIFT;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   localparam logic [2:0] CSR_DIRTY_PCT = 3'd0;
   localparam logic [2:0] CSR_IN_USE = 3'd1;
   localparam logic [2:0] CSR_FLUSH_DLY = 3'd2;
   localparam logic [2:0] CSR_SYNC_PER = 3'd3;
   localparam logic [2:0] CSR_SYNC_LIM = 3'd4;

   typedef enum logic [1:0] {
      M_ACQUIRE = 2'd0,
      M_MARK    = 2'd1,
      M_RELEASE = 2'd2,
      M_NONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      K_ACQ_DONE = 3'd0,
      K_WRITEBACK = 3'd1,
      K_FILL = 3'd2,
      K_REL_DONE = 3'd3,
      K_NO_BUFFER = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ES_FREE  = 2'd0,
      ES_CLEAN = 2'd1,
      ES_DIRTY = 2'd2
   } est_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACQ_SCAN, ST_ACQ_DEC, ST_ACQ_HIT, ST_ACQ_WB, ST_ACQ_FILL,
      ST_ACQ_DONE, ST_MARK, ST_REL_UPD, ST_REL_CHK, ST_FL_SCAN, ST_FL_WB,
      ST_REL_DONE
   } state_type;

   typedef struct packed {
      est_type           est;
      logic [IDX_W-1:0]  rank;
      logic              ref_zero;
      logic              match;
   } entry_view_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic              free_found;
      logic              free_refz;
      logic [IDX_W-1:0]  free_idx;
      logic [IDX_W-1:0]  free_rank;
      logic              clean_found;
      logic              clean_refz;
      logic [IDX_W-1:0]  clean_idx;
      logic [IDX_W-1:0]  clean_rank;
      logic              dirty_found;
      logic [IDX_W-1:0]  dirty_idx;
      logic [IDX_W-1:0]  dirty_rank;
   } scan_res_type;
endpackage
`default_nettype wire

### hw/rtl/bbcc_scan.sv
// Entry scanner: walks entries one per cycle, finds tag hit and oldest per state.
`default_nettype none
module bbcc_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bbcc_pkg::CNT_W-1:0]  lim,
   output logic [bbcc_pkg::IDX_W-1:0]       addr,
   input  wire bbcc_pkg::entry_view_type    ent,
   output logic                             busy,
   output logic                             done,
   output bbcc_pkg::scan_res_type           res
);
   import bbcc_pkg::*;

   logic busy_ff, busy_in, done_ff, done_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   scan_res_type res_ff, res_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ptr_in = ptr_ff;
      lim_in = lim_ff;
      res_in = res_ff;
      if (start) begin
         busy_in = 1'b1;
         ptr_in = '0;
         lim_in = lim;
         res_in = '0;
      end else if (busy_ff) begin
         if (ent.match && !res_ff.hit) begin
            res_in.hit = 1'b1;
            res_in.hit_idx = ptr_ff;
         end
         unique case (ent.est)
            ES_FREE: begin
               if (!res_ff.free_found || ent.rank < res_ff.free_rank) begin
                  res_in.free_found = 1'b1;
                  res_in.free_refz = ent.ref_zero;
                  res_in.free_idx = ptr_ff;
                  res_in.free_rank = ent.rank;
               end
            end
            ES_CLEAN: begin
               if (!res_ff.clean_found || ent.rank < res_ff.clean_rank) begin
                  res_in.clean_found = 1'b1;
                  res_in.clean_refz = ent.ref_zero;
                  res_in.clean_idx = ptr_ff;
                  res_in.clean_rank = ent.rank;
               end
            end
            ES_DIRTY: begin
               if (!res_ff.dirty_found || ent.rank < res_ff.dirty_rank) begin
                  res_in.dirty_found = 1'b1;
                  res_in.dirty_idx = ptr_ff;
                  res_in.dirty_rank = ent.rank;
               end
            end
            default: ;
         endcase
         if ({1'b0, ptr_ff} == lim_ff - CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ptr_ff <= ptr_in;
      lim_ff <= lim_in;
      res_ff <= res_in;
   end

   assign addr = ptr_ff;
   assign busy = busy_ff;
   assign done = done_ff;
   assign res = res_ff;
endmodule
`default_nettype wire

### hw/rtl/block_buffer_cache_controller.sv
// Buffer cache controller top level: entry tables, sequencer and result register.
//
// req_ carries one request beat: acquire by device/block tag, mark an entry
// dirty, or release an entry. rsp_ returns result beats; tuser holds the kind
// and tlast marks the final beat of a request. csr_ writes the five registers
// (dirty percent, buffers in use, flush delay, sync period, sync limit).
// One request is in work at a time; req_tready is high only when idle.
// Tag lookup and victim choice share one scanner that walks one entry per
// cycle. An acquire scans the first lim entries (lim = buffers in service);
// a flush scans all NUM_BUFFERS entries once per writeback and once more
// to close. A stall by the receiver holds the sequencer and lengthens
// the request.
// Results go through a one-beat output register; when the receiver stalls,
// the sequencer holds until the register frees up, losing nothing.
// Synchronous reset empties all entries (free, no tag, recency by index),
// clears counters and loads the register defaults.
`default_nettype none
module block_buffer_cache_controller (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mode[1:0], device_id[33:2], block_number[65:34], buffer_index[69:66], now[100:70]
   input  wire logic [103:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_index[3:0], hit[4], out_device[36:5], out_block[68:37]
   output logic [71:0]       rsp_tdata,
   // kind[2:0]
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [7:0]   csr_wdata
);
   import bbcc_pkg::*;
   `include "assert_macros.svh"

   // configuration
   logic [6:0] dirty_pct_ff;
   logic [4:0] in_use_ff;
   logic [7:0] flush_dly_ff, sync_per_ff;
   logic [4:0] sync_lim_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W+RECIP_W-1:0] thresh_prod;
   logic [THRESH_W-1:0] thresh_ff;
   logic [CNT_W-1:0] lim;

   // entry tables
   logic [31:0] tag_dev_ff [NUM_BUFFERS], tag_dev_in [NUM_BUFFERS];
   logic [31:0] tag_blk_ff [NUM_BUFFERS], tag_blk_in [NUM_BUFFERS];
   est_type est_ff [NUM_BUFFERS], est_in [NUM_BUFFERS];
   logic valid_ff [NUM_BUFFERS], valid_in [NUM_BUFFERS];
   logic [7:0] ref_ff [NUM_BUFFERS], ref_in [NUM_BUFFERS];
   logic [30:0] dl_ff [NUM_BUFFERS], dl_in [NUM_BUFFERS];
   logic [IDX_W-1:0] rank_ff [NUM_BUFFERS], rank_in [NUM_BUFFERS];
   logic [CNT_W-1:0] dc_ff, dc_in;
   logic [30:0] sync_tick_ff, sync_tick_in;

   // sequencer
   state_type state_ff, state_in;
   logic [31:0] dev_ff, dev_in, blk_ff, blk_in;
   logic [IDX_W-1:0] idx_ff, idx_in, cur_ff, cur_in;
   logic [30:0] now_ff, now_in;
   logic cand_ff, cand_in;
   logic [5:0] fl_cnt_ff, fl_cnt_in;
   logic touch_en;

   // result register
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_hit_ff, rsp_hit_in;
   kind_type rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [31:0] rsp_dev_ff, rsp_dev_in, rsp_blk_ff, rsp_blk_in;
   logic can_emit;

   // scanner
   logic scan_start, scan_busy, scan_done;
   logic [CNT_W-1:0] scan_lim;
   logic [IDX_W-1:0] scan_addr, rd_addr;
   entry_view_type ent;
   scan_res_type res;

   logic [31:0] nd_sum;
   logic [30:0] nd;
   logic [7:0] ref_new;
   logic late;

   assign lim = (in_use_ff == '0) ? CNT_W'(1) :
                (in_use_ff > CNT_W'(NUM_BUFFERS)) ? CNT_W'(NUM_BUFFERS) : in_use_ff;

   assign rd_addr = scan_busy ? scan_addr : cur_ff;
   assign ent.est = est_ff[rd_addr];
   assign ent.rank = rank_ff[rd_addr];
   assign ent.ref_zero = (ref_ff[rd_addr] == '0);
   assign ent.match = valid_ff[rd_addr] && tag_dev_ff[rd_addr] == dev_ff
                      && tag_blk_ff[rd_addr] == blk_ff;

   assign scan_lim = (state_ff == ST_IDLE) ? lim : CNT_W'(NUM_BUFFERS);

   bbcc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .lim   (scan_lim),
      .addr  (scan_addr),
      .ent   (ent),
      .busy  (scan_busy),
      .done  (scan_done),
      .res   (res)
   );

   assign can_emit = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign nd_sum = {1'b0, now_ff} + {24'd0, flush_dly_ff};
   assign nd = nd_sum[31] ? MAX31 : nd_sum[30:0];
   assign ref_new = (ref_ff[cur_ff] != '0) ? ref_ff[cur_ff] - 8'd1 : ref_ff[cur_ff];
   assign late = {1'b0, now_ff} > ({1'b0, sync_tick_ff} + {24'd0, sync_per_ff});
   assign thresh_prod = {{RECIP_W{1'b0}}, prod_ff}
                        * {{PROD_W{1'b0}}, RECIP_W'(RECIP_100)};

   always_comb begin
      state_in = state_ff;
      dev_in = dev_ff;
      blk_in = blk_ff;
      idx_in = idx_ff;
      now_in = now_ff;
      cur_in = cur_ff;
      cand_in = cand_ff;
      fl_cnt_in = fl_cnt_ff;
      tag_dev_in = tag_dev_ff;
      tag_blk_in = tag_blk_ff;
      est_in = est_ff;
      valid_in = valid_ff;
      ref_in = ref_ff;
      dl_in = dl_ff;
      dc_in = dc_ff;
      sync_tick_in = sync_tick_ff;
      touch_en = 1'b0;
      scan_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_hit_in = 1'b0;
      rsp_dev_in = rsp_dev_ff;
      rsp_blk_in = rsp_blk_ff;
      rsp_last_in = rsp_last_ff;
      if (can_emit) begin
         rsp_hit_in = 1'b0;
      end else begin
         rsp_hit_in = rsp_hit_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dev_in = req_tdata[33:2];
               blk_in = req_tdata[65:34];
               idx_in = req_tdata[69:66];
               now_in = req_tdata[100:70];
               cur_in = req_tdata[69:66];
               unique case (mode_type'(req_tdata[1:0]))
                  M_ACQUIRE: begin
                     scan_start = 1'b1;
                     state_in = ST_ACQ_SCAN;
                  end
                  M_MARK: state_in = ST_MARK;
                  M_RELEASE: state_in = ST_REL_UPD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACQ_SCAN: begin
            if (scan_done) state_in = ST_ACQ_DEC;
         end
         ST_ACQ_DEC: begin
            priority if (res.hit) begin
               cur_in = res.hit_idx;
               state_in = ST_ACQ_HIT;
            end else if (res.free_found && res.free_refz) begin
               cur_in = res.free_idx;
               state_in = ST_ACQ_FILL;
            end else if (res.clean_found && res.clean_refz) begin
               cur_in = res.clean_idx;
               state_in = ST_ACQ_FILL;
            end else if (res.dirty_found) begin
               cur_in = res.dirty_idx;
               state_in = ST_ACQ_WB;
            end else begin
               if (can_emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in = K_NO_BUFFER;
                  rsp_idx_in = '0;
                  rsp_dev_in = dev_ff;
                  rsp_blk_in = blk_ff;
                  rsp_last_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ACQ_HIT: begin
            if (can_emit) begin
               touch_en = 1'b1;
               if (ref_ff[cur_ff] != 8'hFF) ref_in[cur_ff] = ref_ff[cur_ff] + 8'd1;
               rsp_valid_in = 1'b1;
               rsp_kind_in = K_ACQ_DONE;
               rsp_idx_in = cur_ff;
               rsp_hit_in = 1'b1;
               rsp_dev_in = dev_ff;
               rsp_blk_in = blk_ff;
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ACQ_WB: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = K_WRITEBACK;
               rsp_idx_in = cur_ff;
               rsp_dev_in = tag_dev_ff[cur_ff];
               rsp_blk_in = tag_blk_ff[cur_ff];
               rsp_last_in = 1'b0;
               if (dc_ff != '0) dc_in = dc_ff - CNT_W'(1);
               state_in = ST_ACQ_FILL;
            end
         end
         ST_ACQ_FILL: begin
            if (can_emit) begin
               tag_dev_in[cur_ff] = dev_ff;
               tag_blk_in[cur_ff] = blk_ff;
               est_in[cur_ff] = ES_CLEAN;
               valid_in[cur_ff] = 1'b1;
               ref_in[cur_ff] = 8'd1;
               dl_in[cur_ff] = '0;
               touch_en = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in = K_FILL;
               rsp_idx_in = cur_ff;
               rsp_dev_in = dev_ff;
               rsp_blk_in = blk_ff;
               rsp_last_in = 1'b0;
               state_in = ST_ACQ_DONE;
            end
         end
         ST_ACQ_DONE: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = K_ACQ_DONE;
               rsp_idx_in = cur_ff;
               rsp_dev_in = dev_ff;
               rsp_blk_in = blk_ff;
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if ({1'b0, cur_ff} < lim && est_ff[cur_ff] != ES_FREE) begin
               if (est_ff[cur_ff] != ES_DIRTY) dc_in = dc_ff + CNT_W'(1);
               est_in[cur_ff] = ES_DIRTY;
               touch_en = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_REL_UPD: begin
            cand_in = 1'b0;
            if ({1'b0, cur_ff} < lim) begin
               touch_en = 1'b1;
               if (est_ff[cur_ff] == ES_DIRTY) begin
                  if (nd > dl_ff[cur_ff]) dl_in[cur_ff] = nd;
               end else begin
                  dl_in[cur_ff] = '0;
               end
               ref_in[cur_ff] = ref_new;
               cand_in = (est_ff[cur_ff] == ES_DIRTY) && (ref_new == '0);
            end
            state_in = ST_REL_CHK;
         end
         ST_REL_CHK: begin
            if (cand_ff && ({{(THRESH_W - CNT_W){1'b0}}, dc_ff} > thresh_ff
                            || (late && dc_ff != '0))) begin
               scan_start = 1'b1;
               fl_cnt_in = '0;
               state_in = ST_FL_SCAN;
            end else begin
               state_in = ST_REL_DONE;
            end
         end
         ST_FL_SCAN: begin
            if (scan_done) begin
               if (res.dirty_found && fl_cnt_ff <= {1'b0, sync_lim_ff}) begin
                  cur_in = res.dirty_idx;
                  state_in = ST_FL_WB;
               end else begin
                  sync_tick_in = now_ff;
                  cur_in = idx_ff;
                  state_in = ST_REL_DONE;
               end
            end
         end
         ST_FL_WB: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = K_WRITEBACK;
               rsp_idx_in = cur_ff;
               rsp_dev_in = tag_dev_ff[cur_ff];
               rsp_blk_in = tag_blk_ff[cur_ff];
               rsp_last_in = 1'b0;
               est_in[cur_ff] = ES_CLEAN;
               dl_in[cur_ff] = '0;
               touch_en = 1'b1;
               if (dc_ff != '0) dc_in = dc_ff - CNT_W'(1);
               fl_cnt_in = fl_cnt_ff + 6'd1;
               scan_start = 1'b1;
               state_in = ST_FL_SCAN;
            end
         end
         ST_REL_DONE: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = K_REL_DONE;
               rsp_idx_in = cur_ff;
               rsp_dev_in = tag_dev_ff[cur_ff];
               rsp_blk_in = tag_blk_ff[cur_ff];
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // make cur the newest, close the gap it leaves
      if (touch_en) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (rank_ff[i] > rank_ff[cur_ff]) rank_in[i] = rank_ff[i] - IDX_W'(1);
            else rank_in[i] = rank_ff[i];
         end
         rank_in[cur_ff] = IDX_W'(NUM_BUFFERS - 1);
      end else begin
         rank_in = rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dc_ff <= '0;
         sync_tick_ff <= '0;
         dirty_pct_ff <= 7'd20;
         in_use_ff <= 5'd16;
         flush_dly_ff <= 8'd5;
         sync_per_ff <= 8'd20;
         sync_lim_ff <= 5'd20;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            tag_dev_ff[i] <= '0;
            tag_blk_ff[i] <= '0;
            est_ff[i] <= ES_FREE;
            valid_ff[i] <= 1'b0;
            ref_ff[i] <= '0;
            dl_ff[i] <= '0;
            rank_ff[i] <= IDX_W'(i);
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dc_ff <= dc_in;
         sync_tick_ff <= sync_tick_in;
         tag_dev_ff <= tag_dev_in;
         tag_blk_ff <= tag_blk_in;
         est_ff <= est_in;
         valid_ff <= valid_in;
         ref_ff <= ref_in;
         dl_ff <= dl_in;
         rank_ff <= rank_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DIRTY_PCT: dirty_pct_ff <= csr_wdata[6:0];
               CSR_IN_USE: in_use_ff <= csr_wdata[4:0];
               CSR_FLUSH_DLY: flush_dly_ff <= csr_wdata;
               CSR_SYNC_PER: sync_per_ff <= csr_wdata;
               CSR_SYNC_LIM: sync_lim_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
      dev_ff <= dev_in;
      blk_ff <= blk_in;
      idx_ff <= idx_in;
      now_ff <= now_in;
      cur_ff <= cur_in;
      cand_ff <= cand_in;
      fl_cnt_ff <= fl_cnt_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_dev_ff <= rsp_dev_in;
      rsp_blk_ff <= rsp_blk_in;
      rsp_last_ff <= rsp_last_in;
      // threshold = dirty_percent * lim / 100, two registered steps
      prod_ff <= PROD_W'(dirty_pct_ff) * PROD_W'(lim);
      thresh_ff <= thresh_prod[RECIP_SHIFT +: THRESH_W];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'd0, rsp_blk_ff, rsp_dev_ff, rsp_hit_ff, rsp_idx_ff};
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;

   `ASSERT_RST(a_ready_scan_idle, req_tready |-> !scan_busy, "accepting while scanner runs")
   `ASSERT_RST(a_dirty_bound, dc_ff <= CNT_W'(NUM_BUFFERS), "dirty count above entry count")
   `ASSERT_RST(a_scan_done_state,
      scan_done |-> (state_ff == ST_ACQ_SCAN || state_ff == ST_FL_SCAN),
      "scan finished outside a scan state")
endmodule
`default_nettype wire

### tb/block_buffer_cache_controller_tb.sv
// Self-checking testbench for the buffer cache controller.
`timescale 1ns / 100ps
`default_nettype none
module block_buffer_cache_controller_tb;
   import bbcc_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  idx;
      logic        hit;
      logic [31:0] dev;
      logic [31:0] blk;
      logic        last;
   } beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [7:0]   csr_wdata = '0;

   block_buffer_cache_controller dut (.*);

   always #6 clock = ~clock;

   // predictor copy of the cache
   logic [6:0]  pct;
   logic [4:0]  in_use;
   logic [7:0]  dly;
   logic [7:0]  per;
   logic [4:0]  lim_cfg;
   logic [31:0] m_dev [NUM_BUFFERS];
   logic [31:0] m_blk [NUM_BUFFERS];
   est_type     m_st [NUM_BUFFERS];
   logic        m_val [NUM_BUFFERS];
   logic [7:0]  m_ref [NUM_BUFFERS];
   logic [30:0] m_dl [NUM_BUFFERS];
   logic [3:0]  m_rank [NUM_BUFFERS];
   logic [4:0]  m_dirty;
   logic [30:0] m_sync;

   beat_type expected_beats[$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic int service_count();
      if (in_use == 0) return 1;
      if (in_use > NUM_BUFFERS) return NUM_BUFFERS;
      return in_use;
   endfunction

   function automatic void make_newest(int e);
      logic [3:0] r;
      r = m_rank[e];
      for (int i = 0; i < NUM_BUFFERS; i++) if (m_rank[i] > r) m_rank[i]--;
      m_rank[e] = 4'(NUM_BUFFERS - 1);
   endfunction

   function automatic int oldest_in(est_type st, int n);
      int b;
      b = -1;
      for (int i = 0; i < n; i++)
         if (m_st[i] == st && (b < 0 || m_rank[i] < m_rank[b])) b = i;
      return b;
   endfunction

   function automatic void push_beat(kind_type k, int i, logic h, logic [31:0] d,
                                     logic [31:0] b);
      beat_type t;
      t.kind = k; t.idx = i[3:0]; t.hit = h; t.dev = d; t.blk = b; t.last = 0;
      expected_beats.push_back(t);
   endfunction

   function automatic void model_reset();
      pct = 20; in_use = 16; dly = 5; per = 20; lim_cfg = 20;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         m_dev[i] = 0; m_blk[i] = 0; m_st[i] = ES_FREE; m_val[i] = 0;
         m_ref[i] = 0; m_dl[i] = 0; m_rank[i] = 4'(i);
      end
      m_dirty = 0; m_sync = 0;
   endfunction

   function automatic void predict_request(mode_type md, logic [31:0] dev, logic [31:0] blk,
                                           logic [3:0] idx, logic [30:0] now);
      int n, v, base_cnt, d, done;
      logic [32:0] nd;
      int thresh;
      bit late;
      n = service_count();
      base_cnt = expected_beats.size();
      if (md == M_ACQUIRE) begin
         v = -1;
         for (int i = 0; i < n; i++)
            if (v < 0 && m_val[i] && m_dev[i] == dev && m_blk[i] == blk) v = i;
         if (v >= 0) begin
            make_newest(v);
            if (m_ref[v] < 255) m_ref[v]++;
            push_beat(K_ACQ_DONE, v, 1, dev, blk);
         end else begin
            v = oldest_in(ES_FREE, n);
            if (v >= 0 && m_ref[v] != 0) v = -1;
            if (v < 0) begin
               v = oldest_in(ES_CLEAN, n);
               if (v >= 0 && m_ref[v] != 0) v = -1;
            end
            if (v < 0) v = oldest_in(ES_DIRTY, n);
            if (v < 0) push_beat(K_NO_BUFFER, 0, 0, dev, blk);
            else begin
               if (m_st[v] == ES_DIRTY) begin
                  push_beat(K_WRITEBACK, v, 0, m_dev[v], m_blk[v]);
                  if (m_dirty > 0) m_dirty--;
               end
               m_dev[v] = dev; m_blk[v] = blk; m_st[v] = ES_CLEAN; m_val[v] = 1;
               m_ref[v] = 1; m_dl[v] = 0;
               make_newest(v);
               push_beat(K_FILL, v, 0, dev, blk);
               push_beat(K_ACQ_DONE, v, 0, dev, blk);
            end
         end
      end else if (md == M_MARK) begin
         if (idx < n && m_st[idx] != ES_FREE) begin
            if (m_st[idx] != ES_DIRTY) m_dirty++;
            m_st[idx] = ES_DIRTY;
            make_newest(idx);
         end
      end else if (md == M_RELEASE) begin
         if (idx < n) begin
            make_newest(idx);
            if (m_st[idx] == ES_DIRTY) begin
               nd = now + dly;
               if (nd > MAX31) nd = MAX31;
               if (nd[30:0] > m_dl[idx]) m_dl[idx] = nd[30:0];
            end else m_dl[idx] = 0;
            if (m_ref[idx] > 0) m_ref[idx]--;
            if (m_st[idx] == ES_DIRTY && m_ref[idx] == 0) begin
               thresh = pct * n / 100;
               late = ({1'b0, now} > {1'b0, m_sync} + per);
               if (m_dirty > thresh || (late && m_dirty != 0)) begin
                  done = 0;
                  while (done <= lim_cfg) begin
                     d = oldest_in(ES_DIRTY, NUM_BUFFERS);
                     if (d < 0) break;
                     push_beat(K_WRITEBACK, d, 0, m_dev[d], m_blk[d]);
                     m_st[d] = ES_CLEAN; m_dl[d] = 0;
                     make_newest(d);
                     if (m_dirty > 0) m_dirty--;
                     done++;
                  end
                  m_sync = now;
               end
            end
         end
         push_beat(K_REL_DONE, idx, 0, m_dev[idx], m_blk[idx]);
      end
      if (expected_beats.size() > base_cnt) expected_beats[$].last = 1;
   endfunction

   task automatic send_request(mode_type md, logic [31:0] dev, logic [31:0] blk,
                               logic [3:0] idx, logic [30:0] now);
      @(negedge clock);
      repeat ($urandom_range(0, 8)) @(negedge clock);
      req_tdata <= {3'b0, now, idx, blk, dev, md};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(md, dev, blk, idx, now);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] r, logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= r; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (r)
         CSR_DIRTY_PCT: pct = val[6:0];
         CSR_IN_USE:    in_use = val[4:0];
         CSR_FLUSH_DLY: dly = val;
         CSR_SYNC_PER:  per = val;
         CSR_SYNC_LIM:  lim_cfg = val[4:0];
         default: ;
      endcase
   endtask

   // receiver stall: draw a wait before each result beat
   initial begin
      int wait_n;
      forever begin
         @(negedge clock);
         wait_n = $urandom_range(0, 8);
         if (wait_n != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      beat_type got, exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tuser); got.idx = rsp_tdata[3:0];
         got.hit = rsp_tdata[4]; got.dev = rsp_tdata[36:5];
         got.blk = rsp_tdata[68:37]; got.last = rsp_tlast;
         if (expected_beats.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat %p", got);
         end else begin
            exp_b = expected_beats.pop_front();
            if (got !== exp_b) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", exp_b, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   logic [30:0] tick = 0;

   function automatic logic [31:0] small_tag();
      return $urandom_range(0, 5);
   endfunction

   task automatic test_directed();
      send_request(M_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      send_request(M_ACQUIRE, 0, 0, 0, 1);
      send_request(M_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 2);
      send_request(M_MARK, 0, 0, 0, 3);
      send_request(M_MARK, 0, 0, 15, 3);           // free entry: ignored
      send_request(M_NONE, 1, 1, 1, 3);            // unused mode
      send_request(M_RELEASE, 0, 0, 0, 31'd40);    // late, but entry still held: no flush
      send_request(M_MARK, 0, 0, 1, 41);
      send_request(M_RELEASE, 0, 0, 1, MAX31);     // deadline saturates
      send_request(M_RELEASE, 0, 0, 1, MAX31);     // ref already zero
      send_request(M_RELEASE, 0, 0, 9, 5);
      wait_idle();
      write_reg(CSR_IN_USE, 2);
      send_request(M_ACQUIRE, 7, 7, 0, 0);
      send_request(M_ACQUIRE, 8, 8, 0, 0);
      send_request(M_ACQUIRE, 9, 9, 0, 0);         // no victim
      send_request(M_MARK, 0, 0, 0, 0);
      send_request(M_ACQUIRE, 9, 9, 0, 0);         // dirty victim
      send_request(M_RELEASE, 0, 0, 5, 0);         // outside service
      send_request(M_MARK, 0, 0, 5, 0);
      wait_idle();
      write_reg(CSR_IN_USE, 0);
      send_request(M_ACQUIRE, 1, 2, 0, 0);
      wait_idle();
      write_reg(CSR_IN_USE, 31);
      wait_idle();
   endtask

   task automatic test_random(int count);
      int sel;
      logic [3:0] i;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 19);
         i = 4'($urandom_range(0, service_count() - 1));
         tick = tick + 31'($urandom_range(0, 6));
         if (sel < 8)
            send_request(M_ACQUIRE, small_tag(), small_tag(), 4'($urandom), tick);
         else if (sel < 13) send_request(M_MARK, $urandom, $urandom, i, tick);
         else if (sel < 18) send_request(M_RELEASE, $urandom, $urandom, i, tick);
         else if (sel == 18)
            send_request(mode_type'($urandom_range(0, 3)), $urandom, $urandom,
                         4'($urandom), 31'($urandom >> 1));
         else send_request(M_ACQUIRE, $urandom, $urandom, 4'($urandom), tick);
      end
   endtask

   task automatic test_settings();
      wait_idle();
      write_reg(CSR_DIRTY_PCT, 100); write_reg(CSR_IN_USE, 16);
      write_reg(CSR_FLUSH_DLY, 255); write_reg(CSR_SYNC_PER, 255);
      write_reg(CSR_SYNC_LIM, 31);
      test_random(30);
      wait_idle();
      write_reg(CSR_DIRTY_PCT, 0); write_reg(CSR_IN_USE, 4);
      write_reg(CSR_FLUSH_DLY, 0); write_reg(CSR_SYNC_PER, 0);
      write_reg(CSR_SYNC_LIM, 0);
      test_random(30);
      wait_idle();
      write_reg(CSR_DIRTY_PCT, 127); write_reg(CSR_IN_USE, 8);
      write_reg(CSR_SYNC_LIM, 2); write_reg(CSR_SYNC_PER, 10);
      test_random(30);
   endtask

   initial begin
      model_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(20);
      test_settings();
      wait_idle();
      if (errors == 0 && expected_beats.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/bbcc_pkg.sv
hw/rtl/bbcc_scan.sv
hw/rtl/block_buffer_cache_controller.sv
tb/block_buffer_cache_controller_tb.sv
